// ===== rtl/core/ipv4rhf_pkg.sv =====
`default_nettype none
package ipv4rhf_pkg;

	// verdict codes carried in each result item
	typedef enum logic [2:0] {
		VERDICT_ICMP     = 3'd0,
		VERDICT_UDP      = 3'd1,
		VERDICT_TCP      = 3'd2,
		VERDICT_DROP     = 3'd3,
		VERDICT_NOT_HOST = 3'd4,
		VERDICT_REJECT   = 3'd5
	} verdict_t;

	// register indexes on the APB port (byte address is 4 * index)
	typedef enum logic [2:0] {
		REG_HOST_ADDR   = 3'd0,
		REG_HOST_MASK   = 3'd1,
		REG_HOST_CFGD   = 3'd2,
		REG_LINK_LOOP   = 3'd3,
		REG_OTHER_A     = 3'd4,
		REG_OTHER_B     = 3'd5,
		REG_OTHER_VALID = 3'd6
	} reg_idx_t;

	localparam int unsigned PADDR_W = 5;

	localparam logic [7:0]  L4_ICMP    = 8'd1;
	localparam logic [7:0]  L4_TCP     = 8'd6;
	localparam logic [7:0]  L4_UDP     = 8'd17;
	localparam logic [7:0]  NET_LOOP   = 8'd127;
	localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
	localparam logic [15:0] SUM_GOOD   = 16'hFFFF;
	localparam logic [31:0] BCAST_ALL  = 32'hFFFF_FFFF;

	// interface configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] host_addr;
		logic [31:0] net_mask;
		logic        host_configured;
		logic        link_is_loopback;
		logic [31:0] other_addr_a;
		logic [31:0] other_addr_b;
		logic [1:0]  other_valid;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/ipv4rhf_in_if.sv =====
`default_nettype none
interface ipv4rhf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic        first_word;
	logic [15:0] frame_len;

	modport source (output valid, header_word, first_word, frame_len, input ready);
	modport sink (input valid, header_word, first_word, frame_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ipv4rhf_out_if.sv =====
`default_nettype none
interface ipv4rhf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  protocol;
	logic [5:0]  header_bytes;
	logic [15:0] datagram_len;

	modport source (output valid, verdict, protocol, header_bytes, datagram_len, input ready);
	modport sink (input valid, verdict, protocol, header_bytes, datagram_len, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ipv4rhf_cfg.sv =====
`default_nettype none
module ipv4rhf_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ipv4rhf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output ipv4rhf_pkg::cfg_t                cfg
);
	import ipv4rhf_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_HOST_ADDR:   cfg_q.host_addr        <= pwdata;
				REG_HOST_MASK:   cfg_q.net_mask         <= pwdata;
				REG_HOST_CFGD:   cfg_q.host_configured  <= pwdata[0];
				REG_LINK_LOOP:   cfg_q.link_is_loopback <= pwdata[0];
				REG_OTHER_A:     cfg_q.other_addr_a     <= pwdata;
				REG_OTHER_B:     cfg_q.other_addr_b     <= pwdata;
				REG_OTHER_VALID: cfg_q.other_valid      <= pwdata[1:0];
				default:         ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_HOST_ADDR:   prdata = cfg_q.host_addr;
			REG_HOST_MASK:   prdata = cfg_q.net_mask;
			REG_HOST_CFGD:   prdata = {31'd0, cfg_q.host_configured};
			REG_LINK_LOOP:   prdata = {31'd0, cfg_q.link_is_loopback};
			REG_OTHER_A:     prdata = cfg_q.other_addr_a;
			REG_OTHER_B:     prdata = cfg_q.other_addr_b;
			REG_OTHER_VALID: prdata = {30'd0, cfg_q.other_valid};
			default:         prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/ipv4rhf_judge.sv =====
`default_nettype none
module ipv4rhf_judge (
	input  wire ipv4rhf_pkg::cfg_t cfg,
	input  wire logic [15:0]      sum,
	input  wire logic [15:0]      dgram_len,
	input  wire logic [15:0]      frame_len,
	input  wire logic [5:0]       header_bytes,
	input  wire logic [15:0]      flags_offset,
	input  wire logic [7:0]       protocol,
	input  wire logic [31:0]      src,
	input  wire logic [31:0]      dst,
	output ipv4rhf_pkg::verdict_t verdict
);
	import ipv4rhf_pkg::*;

	logic [31:0] hm;
	logic        hm_two_bits;
	logic        dst_sbc, src_sbc;
	logic        dst_local, src_ok, src_zero, dst_bcast;

	// host part of the subnet, and whether it spans two bits or more
	assign hm          = ~cfg.net_mask;
	assign hm_two_bits = (hm & (hm - 32'd1)) != 32'd0;

	function automatic logic sub_bcast(input logic [31:0] a, input cfg_t c,
			input logic [31:0] h, input logic two);
		logic [31:0] hp;
		hp = a & h;
		return c.host_configured && (((a ^ c.host_addr) & c.net_mask) == 32'd0) && two &&
			(hp == h || hp == 32'd0);
	endfunction

	assign dst_sbc   = sub_bcast(dst, cfg, hm, hm_two_bits);
	assign src_sbc   = sub_bcast(src, cfg, hm, hm_two_bits);
	assign dst_bcast = dst == BCAST_ALL;
	assign src_zero  = src[31:24] == 8'd0;

	// weak-host destination test
	always_comb begin
		if (dst[31:24] == NET_LOOP)
			dst_local = cfg.link_is_loopback;
		else
			dst_local = (cfg.host_configured && dst == cfg.host_addr) ||
				(cfg.other_valid[0] && dst == cfg.other_addr_a) ||
				(cfg.other_valid[1] && dst == cfg.other_addr_b) ||
				dst_bcast || dst_sbc;
	end

	// source must be unicast; loopback only when the host itself is
	always_comb begin
		if (src_zero || src[31:28] == 4'hE || src[31:28] == 4'hF || src_sbc)
			src_ok = 1'b0;
		else if (src[31:24] == NET_LOOP)
			src_ok = cfg.host_addr[31:24] == NET_LOOP;
		else
			src_ok = 1'b1;
	end

	always_comb begin
		if (sum != SUM_GOOD)
			verdict = VERDICT_REJECT;
		else if (dgram_len < {10'd0, header_bytes} || dgram_len > frame_len)
			verdict = VERDICT_REJECT;
		else if (!dst_local)
			verdict = VERDICT_NOT_HOST;
		else if (!(src_zero && dst_bcast) && !src_ok)
			verdict = VERDICT_REJECT;
		else if (flags_offset[13:0] != 14'd0)
			verdict = VERDICT_DROP;
		else if (protocol == L4_ICMP)
			verdict = VERDICT_ICMP;
		else if (protocol == L4_UDP)
			verdict = VERDICT_UDP;
		else if (protocol == L4_TCP)
			verdict = VERDICT_TCP;
		else
			verdict = VERDICT_DROP;
	end
endmodule
`default_nettype wire

// ===== rtl/core/ipv4_receive_header_filter.sv =====
// Pipeline: two registers, input and result. The header word that ends a
//   header, or a first word that fails the early checks, yields a result item.
// Throughput: one header word per cycle while the result output is not stalled;
//   the checksum fold and verdict logic sit between the input and result registers.
// Reset: arst_n clears the configuration, frame state and both valid flags.
`default_nettype none
module ipv4_receive_header_filter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ipv4rhf_in_if.sink                           hdr_in,
	ipv4rhf_out_if.source                        verdict_out,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ipv4rhf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready
);
	import ipv4rhf_pkg::*;

	cfg_t cfg;

	// input register
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        first_s1;
	logic [15:0] flen_s1;

	// frame state
	logic        collecting_q;
	logic [3:0]  words_seen_q, header_words_q;
	logic [15:0] frame_len_q, tot_len_q, flags_q, sum_q;
	logic [7:0]  protocol_q;
	logic [31:0] src_q, dst_q;

	// result register
	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [7:0]  protocol_out_q;
	logic [5:0]  hbytes_q;
	logic [15:0] dlen_q;

	logic        accept, advance;
	logic [3:0]  ihl, ws_inc;
	logic [5:0]  hb_first;
	logic        early_fail, last_word, res_valid;
	logic [15:0] sum_base, sum_next;
	logic [17:0] sum_raw;
	logic [16:0] sum_f1;
	logic [31:0] dst_now;
	verdict_t    judge_v;

	ipv4rhf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance      = valid_s1 && (!out_valid_q || verdict_out.ready);
	assign hdr_in.ready = !valid_s1 || !out_valid_q || verdict_out.ready;
	assign accept       = hdr_in.valid && hdr_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1  <= hdr_in.header_word;
			first_s1 <= hdr_in.first_word;
			flen_s1  <= hdr_in.frame_len;
		end
	end

	// first-word checks
	assign ihl        = word_s1[27:24];
	assign hb_first   = {ihl, 2'b00};
	assign early_fail = flen_s1 < MIN_HDR_BYTES || word_s1[31:28] != 4'd4 ||
		ihl < 4'd5 || {10'd0, hb_first} > flen_s1;

	// ones' complement accumulate, folded back to 16 bits
	assign sum_base = first_s1 ? 16'd0 : sum_q;
	assign sum_raw  = {2'b00, sum_base} + {2'b00, word_s1[31:16]} + {2'b00, word_s1[15:0]};
	assign sum_f1   = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
	assign sum_next = sum_f1[15:0] + {15'd0, sum_f1[16]};

	assign ws_inc    = words_seen_q + 4'd1;
	assign last_word = !first_s1 && collecting_q && ws_inc == header_words_q;
	assign res_valid = first_s1 ? early_fail : last_word;
	assign dst_now   = (words_seen_q == 4'd4) ? word_s1 : dst_q;

	ipv4rhf_judge u_judge (
		.cfg          (cfg),
		.sum          (sum_next),
		.dgram_len    (tot_len_q),
		.frame_len    (frame_len_q),
		.header_bytes ({header_words_q, 2'b00}),
		.flags_offset (flags_q),
		.protocol     (protocol_q),
		.src          (src_q),
		.dst          (dst_now),
		.verdict      (judge_v)
	);

	// frame control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q   <= 1'b0;
			words_seen_q   <= '0;
			header_words_q <= '0;
		end else if (advance) begin
			if (first_s1) begin
				collecting_q <= !early_fail;
				if (!early_fail) begin
					header_words_q <= ihl;
					words_seen_q   <= 4'd1;
				end
			end else if (collecting_q) begin
				words_seen_q <= ws_inc;
				if (last_word)
					collecting_q <= 1'b0;
			end
		end
	end

	// header fields and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= '0;
			tot_len_q   <= '0;
			sum_q       <= '0;
			flags_q     <= '0;
			protocol_q  <= '0;
			src_q       <= '0;
			dst_q       <= '0;
		end else if (advance) begin
			if (first_s1) begin
				if (!early_fail) begin
					frame_len_q <= flen_s1;
					tot_len_q   <= word_s1[15:0];
					sum_q       <= sum_next;
				end
			end else if (collecting_q) begin
				sum_q <= sum_next;
				case (words_seen_q)
					4'd1:    flags_q    <= word_s1[15:0];
					4'd2:    protocol_q <= word_s1[23:16];
					4'd3:    src_q      <= word_s1;
					4'd4:    dst_q      <= word_s1;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && res_valid)
			out_valid_q <= 1'b1;
		else if (verdict_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			if (first_s1) begin
				verdict_q      <= VERDICT_REJECT;
				protocol_out_q <= 8'd0;
				hbytes_q       <= hb_first;
				dlen_q         <= word_s1[15:0];
			end else begin
				verdict_q      <= judge_v;
				protocol_out_q <= protocol_q;
				hbytes_q       <= {header_words_q, 2'b00};
				dlen_q         <= tot_len_q;
			end
		end
	end

	assign verdict_out.valid        = out_valid_q;
	assign verdict_out.verdict      = verdict_q;
	assign verdict_out.protocol     = protocol_out_q;
	assign verdict_out.header_bytes = hbytes_q;
	assign verdict_out.datagram_len = dlen_q;
endmodule
`default_nettype wire

// ===== rtl/core/ipv4rhf_checker.sv =====
`default_nettype none
module ipv4rhf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  verdict,
	input wire logic [7:0]  protocol,
	input wire logic [5:0]  header_bytes,
	input wire logic [15:0] datagram_len
);
	import ipv4rhf_pkg::*;

	// a pending result item stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// no result item in the first cycle out of reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid straight out of reset");

	// dispatch verdicts match the protocol field
	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict != VERDICT_ICMP || protocol == L4_ICMP) &&
			(verdict != VERDICT_UDP || protocol == L4_UDP) &&
			(verdict != VERDICT_TCP || protocol == L4_TCP))
		else $error("dispatch verdict disagrees with protocol");

	// an accepted header has a sane length and total length
	a_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict != VERDICT_REJECT |->
			header_bytes >= 6'd20 && datagram_len >= {10'd0, header_bytes})
		else $error("accepted header with bad lengths");
endmodule

bind ipv4_receive_header_filter ipv4rhf_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (verdict_out.valid),
	.out_ready    (verdict_out.ready),
	.verdict      (verdict_out.verdict),
	.protocol     (verdict_out.protocol),
	.header_bytes (verdict_out.header_bytes),
	.datagram_len (verdict_out.datagram_len)
);
`default_nettype wire
